@@ rtl/core/psrc_pkg.sv @@
// Package for the pair-sum range counter: fixed field widths, register
// indexes and the control struct carried along the cell chain.
// No dependencies.
package psrc_pkg;

   localparam int REG_BITS       = 33;  // sum_low / sum_high registers
   localparam int IN_VALUE_BITS  = 32;  // width of the value field
   localparam int BOUND_BITS     = 34;  // signed window bounds (reg - value)
   localparam int ITEM_BITS      = 10;  // per-request pair count
   localparam int TOTAL_BITS     = 19;  // running pair total
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [REG_BITS-1:0] SUM_LOW_RESET  = '0;
   localparam logic [REG_BITS-1:0] SUM_HIGH_RESET = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SUM_LOW  = 1'b0,
      CSR_SUM_HIGH = 1'b1
   } csr_index_type;

   // Control bits that travel with a request through the chain.
   typedef struct packed {
      logic valid;
      logic start;
      logic ovf;
   } query_ctl_type;

endpackage

@@ rtl/core/psrc_cell.sv @@
// One cell of the pair-sum chain: holds one stored value, tests the passing
// request against it and hands the request on. Depends on psrc_pkg.
module psrc_cell
   import psrc_pkg::*;
#(
   parameter int VALUE_W    = 32,
   parameter int INDEX_W    = 10,
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  query_ctl_type                in_ctl,
   input  logic [VALUE_W-1:0]           in_value,
   input  logic signed [BOUND_BITS-1:0] in_lo,
   input  logic signed [BOUND_BITS-1:0] in_hi,
   input  logic [INDEX_W-1:0]           in_index,
   input  logic [INDEX_W-1:0]           in_hits,
   output query_ctl_type                out_ctl,
   output logic [VALUE_W-1:0]           out_value,
   output logic signed [BOUND_BITS-1:0] out_lo,
   output logic signed [BOUND_BITS-1:0] out_hi,
   output logic [INDEX_W-1:0]           out_index,
   output logic [INDEX_W-1:0]           out_hits
);

   localparam logic [INDEX_W-1:0] MY_INDEX = INDEX_W'(CELL_INDEX);

   logic [VALUE_W-1:0]           stored_ff;
   query_ctl_type                ctl_ff;
   logic [VALUE_W-1:0]           value_ff;
   logic signed [BOUND_BITS-1:0] lo_ff;
   logic signed [BOUND_BITS-1:0] hi_ff;
   logic [INDEX_W-1:0]           index_ff;
   logic [INDEX_W-1:0]           hits_ff;
   logic [INDEX_W-1:0]           hits_in;
   logic signed [BOUND_BITS-1:0] stored_ext;
   logic                         active;
   logic                         hit;
   logic                         store_here;

   // Cells below the request's index hold values of the current set.
   assign active     = in_ctl.valid && !in_ctl.ovf;
   assign stored_ext = $signed(BOUND_BITS'(stored_ff));
   assign hit        = active && (MY_INDEX < in_index)
                       && (stored_ext >= in_lo) && (stored_ext <= in_hi);
   assign store_here = active && (in_index == MY_INDEX);
   assign hits_in    = in_hits + INDEX_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= in_value;
         lo_ff    <= in_lo;
         hi_ff    <= in_hi;
         index_ff <= in_index;
         hits_ff  <= hits_in;
      end
      if (adv && store_here) begin
         stored_ff <= in_value;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_value = value_ff;
   assign out_lo    = lo_ff;
   assign out_hi    = hi_ff;
   assign out_index = index_ff;
   assign out_hits  = hits_ff;

endmodule

@@ rtl/core/psrc_tally.sv @@
// Tail of the pair-sum chain: saturates the per-request count, keeps the
// running total of the set and holds the response registers. Depends on psrc_pkg.
module psrc_tally
   import psrc_pkg::*;
#(
   parameter int INDEX_W = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  query_ctl_type         in_ctl,
   input  logic [INDEX_W-1:0]    in_hits,
   output logic                  rsp_valid,
   output logic [ITEM_BITS-1:0]  rsp_item_pairs,
   output logic [TOTAL_BITS-1:0] rsp_total_pairs,
   output logic                  rsp_overflow
);

   localparam int WIDE_W = (INDEX_W > ITEM_BITS) ? INDEX_W : ITEM_BITS;
   localparam int SUM_W  = ((INDEX_W > TOTAL_BITS) ? INDEX_W : TOTAL_BITS) + 1;
   localparam logic [ITEM_BITS-1:0]  ITEM_MAX  = '1;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] total_in;
   logic                  valid_ff;
   logic [ITEM_BITS-1:0]  item_ff;
   logic [ITEM_BITS-1:0]  item_in;
   logic [TOTAL_BITS-1:0] out_total_ff;
   logic                  ovf_ff;
   logic [TOTAL_BITS-1:0] base;
   logic [WIDE_W-1:0]     hits_wide;
   logic [SUM_W-1:0]      sum;

   always_comb begin
      base      = in_ctl.start ? '0 : total_ff;
      hits_wide = WIDE_W'(in_hits);
      sum       = SUM_W'(base) + SUM_W'(in_hits);
      if (in_ctl.ovf) begin
         item_in  = '0;
         total_in = base;
      end else begin
         item_in  = (hits_wide > WIDE_W'(ITEM_MAX)) ? ITEM_MAX : ITEM_BITS'(hits_wide);
         total_in = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else if (adv) begin
         valid_ff <= in_ctl.valid;
         if (in_ctl.valid) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_ctl.valid) begin
         item_ff      <= item_in;
         out_total_ff <= total_in;
         ovf_ff       <= in_ctl.ovf;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_item_pairs  = item_ff;
   assign rsp_total_pairs = out_total_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

@@ rtl/core/pair_sum_range_counter.sv @@
// A request passes through the head stage, every cell and the tally before its response is valid.
// Throughput: one request per cycle while no response is stalled; each request visits one cell per cycle.
// A stalled response freezes the whole chain, which then holds off requests.
// Reset (synchronous, active high) clears the fill count, the running total and
// all valid bits, presets the window registers; stored values are never cleared.
module pair_sum_range_counter
   import psrc_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [IN_VALUE_BITS-1:0]  req_value,
   input  logic                      req_start_of_set,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ITEM_BITS-1:0]      rsp_item_pairs,
   output logic [TOTAL_BITS-1:0]     rsp_total_pairs,
   output logic                      rsp_overflow,
   // configuration writes
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]       csr_wdata
);

   // Only the low bits of the value field take part when VALUE_BITS is small.
   localparam int VALUE_W = (VALUE_BITS > IN_VALUE_BITS) ? IN_VALUE_BITS : VALUE_BITS;
   // A request index addresses a cell; the fill count must also reach CAPACITY.
   localparam int INDEX_W = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // The design works as a systolic chain. The head stage turns the sum window
   // into a window on the stored value (sum_low - v .. sum_high - v), so each
   // cell needs only two compares. The request carries the fill count it saw
   // on entry as its index: cells below that index count a hit when their value
   // lies in the window, and the cell at that index stores the new value. A
   // later request trails one cell behind, so it always finds the value that an
   // earlier one stored. A start of set resets the fill count and the running total;
   // stale cell contents are ignored because they sit at or above the new index.

   logic [REG_BITS-1:0] sum_low_ff;
   logic [REG_BITS-1:0] sum_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_low_ff  <= SUM_LOW_RESET;
         sum_high_ff <= SUM_HIGH_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SUM_LOW:  sum_low_ff  <= csr_wdata;
            CSR_SUM_HIGH: sum_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole chain moves together unless a finished response waits.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Head stage: fill count, overflow decision and window bounds.
   logic [COUNT_W-1:0]           count_ff;
   logic [COUNT_W-1:0]           count_in;
   logic [COUNT_W-1:0]           count_base;
   logic                         head_ovf;
   logic [VALUE_W-1:0]           value_masked;
   query_ctl_type                head_ctl_ff;
   query_ctl_type                head_ctl_in;
   logic [VALUE_W-1:0]           head_value_ff;
   logic signed [BOUND_BITS-1:0] head_lo_ff;
   logic signed [BOUND_BITS-1:0] head_lo_in;
   logic signed [BOUND_BITS-1:0] head_hi_ff;
   logic signed [BOUND_BITS-1:0] head_hi_in;
   logic [INDEX_W-1:0]           head_index_ff;

   always_comb begin
      value_masked = req_value[VALUE_W-1:0];
      count_base   = req_start_of_set ? '0 : count_ff;
      head_ovf     = count_base >= COUNT_W'(CAPACITY);
      count_in     = count_ff;
      if (adv && req_valid) begin
         count_in = head_ovf ? count_base : count_base + COUNT_W'(1);
      end
      head_ctl_in.valid = req_valid;
      head_ctl_in.start = req_start_of_set;
      head_ctl_in.ovf   = head_ovf;
      head_lo_in = $signed(BOUND_BITS'(sum_low_ff) - BOUND_BITS'(value_masked));
      head_hi_in = $signed(BOUND_BITS'(sum_high_ff) - BOUND_BITS'(value_masked));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         head_ctl_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (adv) begin
            head_ctl_ff <= head_ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         head_value_ff <= value_masked;
         head_lo_ff    <= head_lo_in;
         head_hi_ff    <= head_hi_in;
         head_index_ff <= count_base[INDEX_W-1:0];
      end
   end

   // Links between cells: entry g feeds cell g, entry g+1 is its output.
   query_ctl_type                ctl_link   [CAPACITY+1];
   logic [VALUE_W-1:0]           value_link [CAPACITY+1];
   logic signed [BOUND_BITS-1:0] lo_link    [CAPACITY+1];
   logic signed [BOUND_BITS-1:0] hi_link    [CAPACITY+1];
   logic [INDEX_W-1:0]           index_link [CAPACITY+1];
   logic [INDEX_W-1:0]           hits_link  [CAPACITY+1];

   assign ctl_link[0]   = head_ctl_ff;
   assign value_link[0] = head_value_ff;
   assign lo_link[0]    = head_lo_ff;
   assign hi_link[0]    = head_hi_ff;
   assign index_link[0] = head_index_ff;
   assign hits_link[0]  = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      psrc_cell #(
         .VALUE_W   (VALUE_W),
         .INDEX_W   (INDEX_W),
         .CELL_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_ctl   (ctl_link[g]),
         .in_value (value_link[g]),
         .in_lo    (lo_link[g]),
         .in_hi    (hi_link[g]),
         .in_index (index_link[g]),
         .in_hits  (hits_link[g]),
         .out_ctl  (ctl_link[g+1]),
         .out_value(value_link[g+1]),
         .out_lo   (lo_link[g+1]),
         .out_hi   (hi_link[g+1]),
         .out_index(index_link[g+1]),
         .out_hits (hits_link[g+1])
      );
   end

   // Tail: count saturation, running total and the response registers.
   psrc_tally #(
      .INDEX_W(INDEX_W)
   ) u_tally (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_ctl         (ctl_link[CAPACITY]),
      .in_hits        (hits_link[CAPACITY]),
      .rsp_valid      (rsp_valid),
      .rsp_item_pairs (rsp_item_pairs),
      .rsp_total_pairs(rsp_total_pairs),
      .rsp_overflow   (rsp_overflow)
   );

`ifndef SYNTH
   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // A request that found the store full reports no pairs.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_item_pairs == '0))
      else $error("overflow response with nonzero pair count");

   // The running total always covers the pairs of the current request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_pairs >= TOTAL_BITS'(rsp_item_pairs)))
      else $error("running total below per-request count");

   // Reset empties the response stage.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
